// File: src/assert_macros.svh
// Assertion macros used by the checker file lcb_check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LCB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcb check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define LCB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcb check failed");

`endif

// File: src/lcb_pkg.sv
// Shared widths, latencies and types of the line constraint basis unit.
`timescale 1ns / 1ps
package lcb_pkg;

  localparam int COORD_BITS     = 16;
  localparam int UNIT_FRAC_BITS = 14;

  localparam int AXV_W  = COORD_BITS + 1;      // first cross product component
  localparam int BV_W   = 2 * COORD_BITS + 1;  // second cross product component
  localparam int MAG_W  = 2 * COORD_BITS;      // magnitude of a component, scaled
  localparam int N2_W   = 4 * COORD_BITS;      // squared length
  localparam int SQ_STEPS  = N2_W / 2;         // root bits
  localparam int NSH_STEPS = $clog2(SQ_STEPS); // normalize shifter stages
  localparam int Q_W    = UNIT_FRAC_BITS + 1;  // unit component magnitude
  localparam int DIVD_W = MAG_W + UNIT_FRAC_BITS + 2;
  localparam int DIVS_W = MAG_W + 1;
  localparam int ROW_W  = UNIT_FRAC_BITS + 2;
  localparam int TGT_W  = COORD_BITS + 1;
  localparam int PSUM_W = ROW_W + COORD_BITS;
  localparam int QV_W   = PSUM_W - UNIT_FRAC_BITS;

  localparam int TGT_MAX = (1 << (TGT_W - 1)) - 1;
  localparam int TGT_NEG_LIM = 1 << (TGT_W - 1);

  localparam int FRONT_LAT = 6;
  localparam int NORM_LAT  = NSH_STEPS + SQ_STEPS + Q_W + 2;
  localparam int PROJ_LAT  = 4;
  localparam int TOTAL_LAT = FRONT_LAT + NORM_LAT + PROJ_LAT;

  typedef struct packed {
    logic vld;  // stage holds an item
    logic nz;   // direction of that item is nonzero
  } lcb_ctl_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } lcb_axis_t;

endpackage

// File: src/lcb_front.sv
// Axis pick, both cross products and both squared lengths (six stages).
`timescale 1ns / 1ps
module lcb_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  acc,
  input  logic signed [lcb_pkg::COORD_BITS-1:0] dir [3],
  input  logic signed [lcb_pkg::COORD_BITS-1:0] pos [3],
  output lcb_pkg::lcb_ctl_t                     ctl,
  output logic signed [lcb_pkg::BV_W-1:0]       av [3],
  output logic [lcb_pkg::N2_W-1:0]              n2a,
  output logic signed [lcb_pkg::BV_W-1:0]       bv [3],
  output logic [lcb_pkg::N2_W-1:0]              n2b,
  output logic signed [lcb_pkg::COORD_BITS-1:0] pos_out [3]
);
  import lcb_pkg::*;

  // stage 1: input capture
  logic                         v1;
  logic signed [COORD_BITS-1:0] d1 [3];
  logic signed [COORD_BITS-1:0] p1 [3];

  // stage 2: first cross product
  lcb_ctl_t                     c2;
  logic signed [AXV_W-1:0]      a2 [3];
  logic signed [AXV_W-1:0]      d2 [3];
  logic signed [COORD_BITS-1:0] p2 [3];

  // stage 3: products
  lcb_ctl_t                     c3;
  logic signed [BV_W-1:0]       m3 [6];
  logic signed [2*AXV_W-1:0]    sq3 [3];
  logic signed [AXV_W-1:0]      a3 [3];
  logic signed [COORD_BITS-1:0] p3 [3];

  // stage 4: second cross product, first length
  lcb_ctl_t                     c4;
  logic signed [BV_W-1:0]       b4 [3];
  logic [MAG_W-1:0]             bm4 [3];
  logic [N2_W-1:0]              n2a4;
  logic signed [AXV_W-1:0]      a4 [3];
  logic signed [COORD_BITS-1:0] p4 [3];

  // stage 5: squares of the second vector
  lcb_ctl_t                     c5;
  logic [N2_W-1:0]              bsq5 [3];
  logic signed [BV_W-1:0]       b5 [3];
  logic [N2_W-1:0]              n2a5;
  logic signed [AXV_W-1:0]      a5 [3];
  logic signed [COORD_BITS-1:0] p5 [3];

  // stage 2 combinational
  logic signed [AXV_W-1:0] de [3];
  logic [AXV_W-1:0]        dm [3];
  logic signed [AXV_W-1:0] a2_next [3];
  lcb_axis_t               axis;
  logic                    nz_next;

  // stage 3/4 combinational
  logic signed [BV_W-1:0]    b4_next [3];
  logic signed [BV_W-1:0]    m3_next [6];
  logic signed [2*AXV_W-1:0] sq3_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      de[i] = AXV_W'(d1[i]);
      dm[i] = (de[i] < 0) ? AXV_W'(-de[i]) : AXV_W'(de[i]);
    end
    nz_next = (d1[0] != '0) || (d1[1] != '0) || (d1[2] != '0);
    if (dm[2] <= dm[0] && dm[2] <= dm[1]) begin
      axis = AXIS_Z;
    end else if (dm[1] <= dm[0] && dm[1] <= dm[2]) begin
      axis = AXIS_Y;
    end else begin
      axis = AXIS_X;
    end
    case (axis)
      AXIS_Z: begin
        a2_next[0] = de[1];
        a2_next[1] = -de[0];
        a2_next[2] = '0;
      end
      AXIS_Y: begin
        a2_next[0] = -de[2];
        a2_next[1] = '0;
        a2_next[2] = de[0];
      end
      default: begin
        a2_next[0] = '0;
        a2_next[1] = de[2];
        a2_next[2] = -de[1];
      end
    endcase
  end

  always_comb begin
    m3_next[0] = a2[1] * d2[2];
    m3_next[1] = a2[2] * d2[1];
    m3_next[2] = a2[2] * d2[0];
    m3_next[3] = a2[0] * d2[2];
    m3_next[4] = a2[0] * d2[1];
    m3_next[5] = a2[1] * d2[0];
    for (int i = 0; i < 3; i++) begin
      sq3_next[i] = a2[i] * a2[i];
    end
    for (int i = 0; i < 3; i++) begin
      b4_next[i] = m3[2*i] - m3[2*i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      ctl <= '0;
    end else begin
      v1 <= acc;
      c2 <= '{vld: v1, nz: nz_next};
      c3 <= c2;
      c4 <= c3;
      c5 <= c4;
      ctl <= c5;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (acc) begin
        d1[i] <= dir[i];
        p1[i] <= pos[i];
      end
      a2[i]   <= a2_next[i];
      d2[i]   <= de[i];
      p2[i]   <= p1[i];
      sq3[i]  <= sq3_next[i];
      a3[i]   <= a2[i];
      p3[i]   <= p2[i];
      b4[i]   <= b4_next[i];
      bm4[i]  <= (b4_next[i] < 0) ? MAG_W'(-b4_next[i]) : MAG_W'(b4_next[i]);
      a4[i]   <= a3[i];
      p4[i]   <= p3[i];
      bsq5[i] <= bm4[i] * bm4[i];
      b5[i]   <= b4[i];
      a5[i]   <= a4[i];
      p5[i]   <= p4[i];
      av[i]   <= BV_W'(a5[i]);
      bv[i]   <= b5[i];
      pos_out[i] <= p5[i];
    end
    for (int j = 0; j < 6; j++) begin
      m3[j] <= m3_next[j];
    end
    n2a4 <= N2_W'(sq3[0]) + N2_W'(sq3[1]) + N2_W'(sq3[2]);
    n2a5 <= n2a4;
    n2a  <= n2a5;
    n2b  <= bsq5[0] + bsq5[1] + bsq5[2];
  end

endmodule

// File: src/lcb_norm.sv
// Unit vector pipeline: pair shifter, bitwise root, three restoring dividers.
`timescale 1ns / 1ps
module lcb_norm (
  input  logic                             clk,
  input  logic                             rst,
  input  lcb_pkg::lcb_ctl_t                ctl_in,
  input  logic signed [lcb_pkg::BV_W-1:0]  vec [3],
  input  logic [lcb_pkg::N2_W-1:0]         n2,
  output lcb_pkg::lcb_ctl_t                ctl_out,
  output logic signed [lcb_pkg::ROW_W-1:0] unit [3]
);
  import lcb_pkg::*;

  // normalize: shift n2 left by pairs until one of the top two bits is set
  lcb_ctl_t         nctl [NSH_STEPS+1];
  logic [N2_W-1:0]  nn   [NSH_STEPS+1];
  logic [MAG_W-1:0] nmag [NSH_STEPS+1][3];
  logic             nneg [NSH_STEPS+1][3];

  always_comb begin
    nctl[0] = ctl_in;
    nn[0]   = n2;
    for (int i = 0; i < 3; i++) begin
      nneg[0][i] = vec[i][BV_W-1];
      nmag[0][i] = vec[i][BV_W-1] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
    end
  end

  for (genvar j = 0; j < NSH_STEPS; j++) begin : g_nsh
    localparam int SH = 1 << (NSH_STEPS - 1 - j);
    logic take;
    assign take = (nn[j][N2_W-1 -: 2*SH] == '0);
    always_ff @(posedge clk) begin
      if (rst) begin
        nctl[j+1] <= '0;
      end else begin
        nctl[j+1] <= nctl[j];
      end
    end
    always_ff @(posedge clk) begin
      nn[j+1] <= take ? (nn[j] << (2*SH)) : nn[j];
      for (int i = 0; i < 3; i++) begin
        nmag[j+1][i] <= take ? (nmag[j][i] << SH) : nmag[j][i];
        nneg[j+1][i] <= nneg[j][i];
      end
    end
  end

  // square root, one result bit per stage
  lcb_ctl_t         sctl [SQ_STEPS+1];
  logic [N2_W-1:0]  srem [SQ_STEPS+1];
  logic [N2_W-1:0]  sroot [SQ_STEPS+1];
  logic [MAG_W-1:0] smag [SQ_STEPS+1][3];
  logic             sneg [SQ_STEPS+1][3];

  always_comb begin
    sctl[0]  = nctl[NSH_STEPS];
    srem[0]  = nn[NSH_STEPS];
    sroot[0] = '0;
    for (int i = 0; i < 3; i++) begin
      smag[0][i] = nmag[NSH_STEPS][i];
      sneg[0][i] = nneg[NSH_STEPS][i];
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [N2_W-1:0] BIT = N2_W'(1) << (N2_W - 2 - 2*k);
    logic [N2_W-1:0] trial;
    logic            fit;
    assign trial = sroot[k] + BIT;
    assign fit   = (srem[k] >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        sctl[k+1] <= '0;
      end else begin
        sctl[k+1] <= sctl[k];
      end
    end
    always_ff @(posedge clk) begin
      srem[k+1]  <= fit ? (srem[k] - trial) : srem[k];
      sroot[k+1] <= fit ? ((sroot[k] >> 1) + BIT) : (sroot[k] >> 1);
      for (int i = 0; i < 3; i++) begin
        smag[k+1][i] <= smag[k][i];
        sneg[k+1][i] <= sneg[k][i];
      end
    end
  end

  // division: (2*num + r) / (2*r), num = mag << frac bits
  lcb_ctl_t          dctl [Q_W+1];
  logic [DIVD_W-1:0] drem [Q_W+1][3];
  logic [DIVS_W-1:0] ddiv [Q_W+1];
  logic [Q_W-1:0]    dq   [Q_W+1][3];
  logic              dneg [Q_W+1][3];
  logic [MAG_W-1:0]  root;

  assign root = sroot[SQ_STEPS][MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dctl[0] <= '0;
    end else begin
      dctl[0] <= sctl[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    ddiv[0] <= DIVS_W'(root) << 1;
    for (int i = 0; i < 3; i++) begin
      drem[0][i] <= (DIVD_W'(smag[SQ_STEPS][i]) << (UNIT_FRAC_BITS + 1)) + DIVD_W'(root);
      dq[0][i]   <= '0;
      dneg[0][i] <= sneg[SQ_STEPS][i];
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    localparam int SH = Q_W - 1 - k;
    logic [DIVD_W-1:0] step;
    logic              fit [3];
    assign step = DIVD_W'(ddiv[k]) << SH;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        fit[i] = (drem[k][i] >= step);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dctl[k+1] <= '0;
      end else begin
        dctl[k+1] <= dctl[k];
      end
    end
    always_ff @(posedge clk) begin
      ddiv[k+1] <= ddiv[k];
      for (int i = 0; i < 3; i++) begin
        drem[k+1][i] <= fit[i] ? (drem[k][i] - step) : drem[k][i];
        dq[k+1][i]   <= {dq[k][i][Q_W-2:0], fit[i]};
        dneg[k+1][i] <= dneg[k][i];
      end
    end
  end

  // sign and zero-direction clear
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= dctl[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (!dctl[Q_W].nz) begin
        unit[i] <= '0;
      end else if (dneg[Q_W][i]) begin
        unit[i] <= -ROW_W'(dq[Q_W][i]);
      end else begin
        unit[i] <= ROW_W'(dq[Q_W][i]);
      end
    end
  end

endmodule

// File: src/lcb_proj.sv
// Projection of the point onto both rows, rounding and saturation (four stages).
`timescale 1ns / 1ps
module lcb_proj (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lcb_pkg::lcb_ctl_t                     ctl,
  input  logic signed [lcb_pkg::ROW_W-1:0]      r0 [3],
  input  logic signed [lcb_pkg::ROW_W-1:0]      r1 [3],
  input  logic signed [lcb_pkg::COORD_BITS-1:0] pos [3],
  output logic signed [lcb_pkg::ROW_W-1:0]      row0 [3],
  output logic signed [lcb_pkg::ROW_W-1:0]      row1 [3],
  output logic signed [lcb_pkg::TGT_W-1:0]      tgt_a,
  output logic signed [lcb_pkg::TGT_W-1:0]      tgt_b,
  output logic                                  valid_res,
  output logic                                  done
);
  import lcb_pkg::*;

  lcb_ctl_t                c1, c2, c3;
  logic signed [ROW_W-1:0] r0_d [3][3];
  logic signed [ROW_W-1:0] r1_d [3][3];

  logic signed [PSUM_W-1:0] pr0 [3];
  logic signed [PSUM_W-1:0] pr1 [3];
  logic signed [PSUM_W-1:0] s0, s1;
  logic [PSUM_W-1:0]        mr0, mr1;
  logic                     ng0, ng1;
  logic [QV_W-1:0]          qv0, qv1;
  logic [PSUM_W-1:0]        mag0, mag1;

  localparam logic [PSUM_W-1:0] HALF = PSUM_W'(1) << (UNIT_FRAC_BITS - 1);

  assign mag0 = (s0 < 0) ? PSUM_W'(-s0) : PSUM_W'(s0);
  assign mag1 = (s1 < 0) ? PSUM_W'(-s1) : PSUM_W'(s1);
  assign qv0  = mr0[PSUM_W-1:UNIT_FRAC_BITS];
  assign qv1  = mr1[PSUM_W-1:UNIT_FRAC_BITS];

  function automatic logic signed [TGT_W-1:0] sat(input logic [QV_W-1:0] q,
                                                  input logic neg);
    logic signed [TGT_W-1:0] res;
    if (neg) begin
      res = (q > QV_W'(TGT_NEG_LIM)) ? -TGT_W'(TGT_NEG_LIM) : -TGT_W'(q);
    end else begin
      res = (q > QV_W'(TGT_MAX)) ? TGT_W'(TGT_MAX) : TGT_W'(q);
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      c1        <= '0;
      c2        <= '0;
      c3        <= '0;
      done      <= 1'b0;
      valid_res <= 1'b0;
    end else begin
      c1        <= ctl;
      c2        <= c1;
      c3        <= c2;
      done      <= c3.vld;
      valid_res <= c3.nz;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pr0[i]     <= r0[i] * pos[i];
      pr1[i]     <= r1[i] * pos[i];
      r0_d[0][i] <= r0[i];
      r1_d[0][i] <= r1[i];
      r0_d[1][i] <= r0_d[0][i];
      r1_d[1][i] <= r1_d[0][i];
      r0_d[2][i] <= r0_d[1][i];
      r1_d[2][i] <= r1_d[1][i];
      row0[i]    <= r0_d[2][i];
      row1[i]    <= r1_d[2][i];
    end
    s0    <= pr0[0] + pr0[1] + pr0[2];
    s1    <= pr1[0] + pr1[1] + pr1[2];
    mr0   <= mag0 + HALF;
    mr1   <= mag1 + HALF;
    ng0   <= s0[PSUM_W-1];
    ng1   <= s1[PSUM_W-1];
    tgt_a <= sat(qv0, ng0);
    tgt_b <= sat(qv1, ng1);
  end

endmodule

// File: src/line_constraint_basis_unit.sv
// Top level of the line constraint basis unit.
`timescale 1ns / 1ps
// Line constraint basis unit. One transfer carries a line direction and a
// point on the line (signed Q8.8). At the pipeline's end the unit shows,
// for exactly one cycle with done high, two orthonormal rows in Q1.14 that
// span the plane normal to the direction, and the point projected onto each
// row in Q9.8 (rounded half away from zero, saturated to 17 bits).
// The least aligned axis is picked from the direction magnitudes, with ties
// going to Z, then Y, else X. A zero direction gives valid_res low and all
// fields zero. The unit is fully pipelined: a new transfer may start in
// every cycle and results leave in the order items came in. There is no
// back-pressure from the receiver, so done must be taken when it is shown.
// Busy is high only during reset. The front end (axis pick, two cross
// products, squared lengths) feeds the unit-vector pipeline (5 normalize,
// 32 square root steps, divider setup, 15 quotient steps, sign), which
// feeds the projection. The square root stages, one result bit per stage
// on a 64-bit remainder, set the depth.
module line_constraint_basis_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [lcb_pkg::COORD_BITS-1:0] dir_x,
  input  logic signed [lcb_pkg::COORD_BITS-1:0] dir_y,
  input  logic signed [lcb_pkg::COORD_BITS-1:0] dir_z,
  input  logic signed [lcb_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [lcb_pkg::COORD_BITS-1:0] pos_y,
  input  logic signed [lcb_pkg::COORD_BITS-1:0] pos_z,
  output logic                                  done,
  output logic signed [lcb_pkg::ROW_W-1:0]      row0_x,
  output logic signed [lcb_pkg::ROW_W-1:0]      row0_y,
  output logic signed [lcb_pkg::ROW_W-1:0]      row0_z,
  output logic signed [lcb_pkg::ROW_W-1:0]      row1_x,
  output logic signed [lcb_pkg::ROW_W-1:0]      row1_y,
  output logic signed [lcb_pkg::ROW_W-1:0]      row1_z,
  output logic signed [lcb_pkg::TGT_W-1:0]      target_a,
  output logic signed [lcb_pkg::TGT_W-1:0]      target_b,
  output logic                                  valid_res
);
  import lcb_pkg::*;

  logic                         acc;
  logic signed [COORD_BITS-1:0] dir [3];
  logic signed [COORD_BITS-1:0] pos [3];

  // front end results
  lcb_ctl_t                     f_ctl;
  logic signed [BV_W-1:0]       f_av [3];
  logic signed [BV_W-1:0]       f_bv [3];
  logic [N2_W-1:0]              f_n2a;
  logic [N2_W-1:0]              f_n2b;
  logic signed [COORD_BITS-1:0] f_pos [3];

  // unit vectors
  lcb_ctl_t                     u_ctl;
  logic signed [ROW_W-1:0]      u_r0 [3];
  logic signed [ROW_W-1:0]      u_r1 [3];

  // point delay, matched to the unit-vector pipeline
  logic signed [COORD_BITS-1:0] pdl [NORM_LAT][3];

  logic signed [ROW_W-1:0]      row0 [3];
  logic signed [ROW_W-1:0]      row1 [3];

  // no transfer is taken while the pipeline valid bits are being cleared
  assign busy = rst;
  assign acc  = start && !busy;

  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;
  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  lcb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .dir     (dir),
    .pos     (pos),
    .ctl     (f_ctl),
    .av      (f_av),
    .n2a     (f_n2a),
    .bv      (f_bv),
    .n2b     (f_n2b),
    .pos_out (f_pos)
  );

  // first row: d x e
  lcb_norm u_norm_a (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (f_ctl),
    .vec     (f_av),
    .n2      (f_n2a),
    .ctl_out (u_ctl),
    .unit    (u_r0)
  );

  // second row: (d x e) x d, same latency, control taken from the first
  lcb_norm u_norm_b (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (f_ctl),
    .vec     (f_bv),
    .n2      (f_n2b),
    .ctl_out (),
    .unit    (u_r1)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pdl[0][i] <= f_pos[i];
      for (int k = 1; k < NORM_LAT; k++) begin
        pdl[k][i] <= pdl[k-1][i];
      end
    end
  end

  lcb_proj u_proj (
    .clk       (clk),
    .rst       (rst),
    .ctl       (u_ctl),
    .r0        (u_r0),
    .r1        (u_r1),
    .pos       (pdl[NORM_LAT-1]),
    .row0      (row0),
    .row1      (row1),
    .tgt_a     (target_a),
    .tgt_b     (target_b),
    .valid_res (valid_res),
    .done      (done)
  );

  assign row0_x = row0[0];
  assign row0_y = row0[1];
  assign row0_z = row0[2];
  assign row1_x = row1[0];
  assign row1_y = row1[1];
  assign row1_z = row1[2];

endmodule

// File: src/lcb_check.sv
// Port-level checks of the line constraint basis unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcb_check (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  done,
  input logic                                  valid_res,
  input logic signed [lcb_pkg::COORD_BITS-1:0] dir_x,
  input logic signed [lcb_pkg::COORD_BITS-1:0] dir_y,
  input logic signed [lcb_pkg::COORD_BITS-1:0] dir_z,
  input logic signed [lcb_pkg::ROW_W-1:0]      row0_x,
  input logic signed [lcb_pkg::ROW_W-1:0]      row1_x,
  input logic signed [lcb_pkg::TGT_W-1:0]      target_a,
  input logic signed [lcb_pkg::TGT_W-1:0]      target_b
);
  import lcb_pkg::*;

  logic dir_nz;

  assign dir_nz = (dir_x != 0) || (dir_y != 0) || (dir_z != 0);

  // every accepted transfer comes out after the fixed latency
  `LCB_ASSERT_IMP(a_lat_out, start && !busy, ##TOTAL_LAT done)

  // no result without a transfer that latency ago
  `LCB_ASSERT_IMP(a_no_ghost, done, $past(start && !busy, TOTAL_LAT))

  // valid flag follows the direction of the matching transfer
  `LCB_ASSERT_IMP(a_valid_dir, done, valid_res == $past(dir_nz, TOTAL_LAT))

  // zero direction clears the result fields
  `LCB_ASSERT_IMP(a_zero_out, done && !valid_res, row0_x == 0 && row1_x == 0 && target_a == 0 && target_b == 0)

endmodule

bind line_constraint_basis_unit lcb_check u_lcb_check (.*);
